### rtl/core/frbr_pkg.sv
// package for the fractional boxcar resampler
// types, constants and controller states shared by all core files
`timescale 1ns / 1ps

package frbr_pkg;

  localparam int RATE_BITS_DEF = 24;
  localparam int SAMPLE_W      = 16;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  localparam int unsigned FAST_RATE_RESET = 48000;
  localparam int unsigned SLOW_RATE_RESET = 48000;

  // register index, taken from the word address
  localparam logic REG_FAST_RATE = 1'b0;
  localparam logic REG_SLOW_RATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO,
    ST_LOAD,
    ST_QUOT,
    ST_SEND
  } frbr_state_t;

  typedef struct packed {
    logic take;
    logic step;
    logic quot_init;
    logic send;
  } frbr_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } frbr_status_t;

endpackage

### rtl/core/frbr_in_if.sv
// input sample channel of the resampler
// depends on frbr_pkg for the sample width
`timescale 1ns / 1ps

interface frbr_in_if
  import frbr_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### rtl/core/frbr_out_if.sv
// result channel of the resampler
// depends on frbr_pkg for the sample width
`timescale 1ns / 1ps

interface frbr_out_if
  import frbr_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

### rtl/core/frbr_regs.sv
// apb register block: fast_rate and slow_rate
// depends on frbr_pkg for bus widths, reset values and register indexes
`timescale 1ns / 1ps

module frbr_regs
  import frbr_pkg::*;
#(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [RATE_BITS-1:0]  fast_rate,
  output logic [RATE_BITS-1:0]  slow_rate
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_rate <= RATE_BITS'(FAST_RATE_RESET);
      slow_rate <= RATE_BITS'(SLOW_RATE_RESET);
    end else if (wr_en) begin
      unique case (reg_index)
        REG_FAST_RATE: fast_rate <= pwdata[RATE_BITS-1:0];
        REG_SLOW_RATE: slow_rate <= pwdata[RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_FAST_RATE: prdata = APB_DATA_W'(fast_rate);
      REG_SLOW_RATE: prdata = APB_DATA_W'(slow_rate);
      default:       prdata = '0;
    endcase
  end

endmodule

### rtl/core/frbr_ctrl.sv
// controller state machine: accept, ratio divide, quotient divide, send
// depends on frbr_pkg for state, command and status types
`timescale 1ns / 1ps

module frbr_ctrl
  import frbr_pkg::*;
#(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  frbr_status_t status,
  output frbr_cmd_t    cmd
);

  localparam int SUM_W = RATE_BITS + SAMPLE_W;
  localparam int CNT_W = $clog2(SUM_W);

  frbr_state_t      state;
  frbr_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic             ratio_last;
  logic             quot_last;

  assign ratio_last = (cnt == CNT_W'(RATE_BITS - 1));
  assign quot_last  = (cnt == CNT_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RATIO) begin
        cnt <= ratio_last ? '0 : cnt + 1'b1;
      end else if (state == ST_QUOT) begin
        cnt <= quot_last ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && status.hit) state_next = ST_RATIO;
      ST_RATIO: if (ratio_last) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_QUOT;
      ST_QUOT:  if (quot_last) state_next = ST_SEND;
      ST_SEND:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_RATIO: cmd.step = 1'b1;
      ST_LOAD:  cmd.quot_init = 1'b1;
      ST_QUOT:  cmd.step = 1'b1;
      ST_SEND:  cmd.send = status.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/frbr_dp.sv
// datapath: running sum, phase, shared restoring divider, output register
// depends on frbr_pkg for command and status types
`timescale 1ns / 1ps

module frbr_dp
  import frbr_pkg::*;
#(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  frbr_cmd_t                  cmd,
  output frbr_status_t               status,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [RATE_BITS-1:0]       fast_rate,
  input  logic [RATE_BITS-1:0]       slow_rate,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  localparam int SUM_W = RATE_BITS + SAMPLE_W;
  localparam int PH_W  = RATE_BITS + 1;

  logic [SUM_W-1:0]     running_sum;
  logic [PH_W-1:0]      phase;
  logic [SUM_W-1:0]     mag;
  logic                 neg;
  logic [SUM_W-1:0]     dvd;
  logic [RATE_BITS-1:0] rem;
  logic [RATE_BITS-1:0] divisor;

  logic [SUM_W-1:0]     sum_next;
  logic [PH_W-1:0]      phase_sum;
  logic                 hit;
  logic [RATE_BITS:0]   trial;
  logic [RATE_BITS:0]   diff;
  logic                 ge;
  logic [RATE_BITS-1:0] ratio_q;
  logic [RATE_BITS-1:0] ratio_clamped;
  logic [SAMPLE_W-1:0]  q_low;

  assign sum_next  = running_sum + {{RATE_BITS{sample[SAMPLE_W-1]}}, sample};
  assign phase_sum = phase + {1'b0, slow_rate};
  assign hit       = phase_sum >= {1'b0, fast_rate};

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem, dvd[SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  // ratio below one or zero slow rate divides by one
  assign ratio_q       = dvd[RATE_BITS-1:0];
  assign ratio_clamped = ((slow_rate == '0) || (ratio_q == '0)) ?
                         RATE_BITS'(1) : ratio_q;
  assign q_low         = dvd[SAMPLE_W-1:0];

  assign status.hit      = hit;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      phase       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (hit) begin
          running_sum <= '0;
          phase       <= phase_sum - {1'b0, fast_rate};
        end else begin
          running_sum <= sum_next;
          phase       <= phase_sum;
        end
      end
      if (cmd.send) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && hit) begin
      neg     <= sum_next[SUM_W-1];
      mag     <= sum_next[SUM_W-1] ? (SUM_W'(0) - sum_next) : sum_next;
      dvd     <= {fast_rate, {SAMPLE_W{1'b0}}};
      rem     <= '0;
      divisor <= slow_rate;
    end else if (cmd.quot_init) begin
      dvd     <= mag;
      rem     <= '0;
      divisor <= ratio_clamped;
    end else if (cmd.step) begin
      dvd <= {dvd[SUM_W-2:0], ge};
      rem <= ge ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
    end
    if (cmd.send) begin
      out_sample <= neg ? (SAMPLE_W'(0) - q_low) : q_low;
    end
  end

endmodule

### rtl/core/fractional_boxcar_resampler_unit.sv
// Fractional boxcar resampler: each accepted sample is added to a running sum and slow_rate
// is added to a phase; once the phase reaches fast_rate the sum is divided (toward zero) by
// fast_rate / slow_rate (a ratio of zero counts as one) and the low 16 bits come out. An
// item that yields no result leaves the input open for the next item. For an item that
// yields a result, one shared bit-serial divider is used twice: the unit accepts the item,
// forms the ratio, reloads the divider, forms the quotient and hands the result over, in
// that order. The result register lets the next item in while a result still waits to be
// taken.
// depends on frbr_pkg, frbr_in_if, frbr_out_if, frbr_regs, frbr_ctrl, frbr_dp
`timescale 1ns / 1ps

module fractional_boxcar_resampler_unit
  import frbr_pkg::*;
#(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  frbr_in_if.sink               feed,
  frbr_out_if.source            result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RATE_BITS-1:0] fast_rate;
  logic [RATE_BITS-1:0] slow_rate;
  frbr_cmd_t            cmd;
  frbr_status_t         status;

  frbr_regs #(.RATE_BITS(RATE_BITS)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .fast_rate (fast_rate),
    .slow_rate (slow_rate)
  );

  frbr_ctrl #(.RATE_BITS(RATE_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .status   (status),
    .cmd      (cmd)
  );

  frbr_dp #(.RATE_BITS(RATE_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample     (feed.sample),
    .fast_rate  (fast_rate),
    .slow_rate  (slow_rate),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_sample (result.out_sample)
  );

`ifndef ASSERT_OFF
  // a request that crosses the threshold keeps the input closed during the divide
  a_busy_after_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.hit) |=> !feed.ready)
    else $error("input open right after a thresholded request");

  // the result register is loaded only when it is free
  a_send_free: assert property (@(posedge clk) disable iff (rst)
    cmd.send |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");

  // accepting and dividing never overlap
  a_take_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !(cmd.step || cmd.quot_init || cmd.send))
    else $error("request accepted while the divider is busy");
`endif

endmodule
